[rtl/rtwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwc_pkg: shared types and constants of the route time window checker
// Field widths of the stream payloads, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package rtwc_pkg;

  localparam int CoordBitsDef = 12;
  localparam int FracBitsDef  = 16;

  localparam int CoordFieldW = 12;
  localparam int TimeFieldW  = 16;
  localparam int DemandW     = 16;
  localparam int LoadW       = 24;
  localparam int TimeW       = 32;

  localparam int InDataW  = 88;
  localparam int OutDataW = 64;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [LoadW-1:0] LoadMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEPOT_X   = 2'd0,
    REG_DEPOT_Y   = 2'd1,
    REG_DEPOT_DUE = 2'd2,
    REG_VEH_CAP   = 2'd3
  } rtwc_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_ADD,
    ST_OPEN,
    ST_SERVE,
    ST_CHECK
  } rtwc_state_e;

endpackage

[rtl/rtwc_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwc_sqrt: bit-serial fixed-point square root
// Restoring digit recurrence, one root bit per cycle. The radicand is shifted
// out two bits a cycle; zero pairs follow for the fractional root bits.
// ----------------------------------------------------------------------------
module rtwc_sqrt #(
  parameter int COORD_BITS = rtwc_pkg::CoordBitsDef,
  parameter int FRAC_BITS  = rtwc_pkg::FracBitsDef,
  localparam int RadW  = 2 * COORD_BITS + 2,
  localparam int RootW = COORD_BITS + FRAC_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  localparam int RemW = RootW + 2;
  localparam int CntW = $clog2(RootW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q;
  logic [RootW-1:0] root_q;

  logic [RemW-1:0] rem_sh;
  logic [RemW-1:0] trial;
  logic            take;

  always_comb begin
    rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
    trial  = {root_q, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= take ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[rtl/route_time_window_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_time_window_check: time window and capacity check of one vehicle route
// Customers stream in visiting order; one result is sent per route.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------------
//  s_axis    | in        | customer, window and service fields, tlast ends route
//  m_axis    | out       | feasible, route_time (Q.FRAC_BITS), route_load
//  cfg       | in        | depot_x, depot_y, depot_due, capacity
//
//  Each customer passes through the leg difference, the squares, the bit-serial
//  square root of the travel leg, the add, the window wait and the service
//  before the next is accepted. The last customer of a route adds the return
//  leg and the final check.
//  Reset returns to route start with the depot at 0,0 and due/capacity 65535.
//  A result held on m_axis does not block the next customer; only the final
//  check of the next route waits for it to be taken.
// ----------------------------------------------------------------------------
module route_time_window_check #(
  parameter int COORD_BITS = rtwc_pkg::CoordBitsDef,
  parameter int FRAC_BITS  = rtwc_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // customer_x, customer_y, customer_demand, window_open, window_close,
  // service_duration (lowest bit up)
  input  logic [rtwc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // feasible, route_time, route_load, zero fill (lowest bit up)
  output logic [rtwc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [rtwc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtwc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int FieldW = rtwc_pkg::CoordFieldW;
  localparam int CW     = (COORD_BITS < FieldW) ? COORD_BITS : FieldW;
  localparam int RadW   = 2 * COORD_BITS + 2;
  localparam int RootW  = COORD_BITS + FRAC_BITS + 1;
  localparam int TimeW  = rtwc_pkg::TimeW;
  localparam int LoadW  = rtwc_pkg::LoadW;
  localparam int TfW    = rtwc_pkg::TimeFieldW;
  localparam int TW     = TfW + FRAC_BITS;
  localparam int SumW   = ((RootW > TimeW) ? RootW : TimeW) + 1;
  localparam int CmpW   = ((TW > TimeW) ? TW : TimeW) + 1;

  // configuration registers
  logic [FieldW-1:0] depot_x_q, depot_y_q;
  logic [TfW-1:0]    depot_due_q, veh_cap_q;

  // route state
  rtwc_pkg::rtwc_state_e state_q, state_d;
  logic              at_start_q, ok_q, leg_home_q;
  logic [CW-1:0]     pos_x_q, pos_y_q;
  logic [TimeW-1:0]  elapsed_q, elapsed_d;
  logic [LoadW-1:0]  load_q;
  logic              m_valid_q;
  logic [rtwc_pkg::OutDataW-1:0] out_data_q;

  // current request
  logic [CW-1:0]     item_x_q, item_y_q;
  logic [TfW-1:0]    open_q, close_q, serv_q;
  logic              last_q;

  // leg datapath
  logic [CW-1:0]     dx_q, dy_q;
  logic [2*CW-1:0]   sq_q;
  logic [2*CW:0]     d2;
  logic [RootW-1:0]  root;
  logic              sqrt_done, sqrt_start;
  logic [CW-1:0]     ax, ay, bx, by;

  logic              accept, emit, late, fin_ok;
  logic [SumW-1:0]   leg_sum;
  logic [TimeW-1:0]  leg_sat;
  logic [CmpW-1:0]   open_ext, serv_sum, close_ext, due_ext;
  logic [LoadW:0]    load_sum;
  logic [LoadW-1:0]  load_base;
  logic [rtwc_pkg::DemandW-1:0] demand;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign demand = s_axis_tdata[39:24];

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    sqrt_start    = 1'b0;
    emit          = 1'b0;
    unique case (state_q)
      rtwc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = rtwc_pkg::ST_DIFF;
      end
      rtwc_pkg::ST_DIFF: state_d = rtwc_pkg::ST_SQX;
      rtwc_pkg::ST_SQX:  state_d = rtwc_pkg::ST_SQY;
      rtwc_pkg::ST_SQY: begin
        sqrt_start = 1'b1;
        state_d    = rtwc_pkg::ST_ROOT;
      end
      rtwc_pkg::ST_ROOT: begin
        if (sqrt_done) state_d = rtwc_pkg::ST_ADD;
      end
      rtwc_pkg::ST_ADD: begin
        state_d = leg_home_q ? rtwc_pkg::ST_CHECK : rtwc_pkg::ST_OPEN;
      end
      rtwc_pkg::ST_OPEN: state_d = rtwc_pkg::ST_SERVE;
      rtwc_pkg::ST_SERVE: begin
        state_d = last_q ? rtwc_pkg::ST_DIFF : rtwc_pkg::ST_IDLE;
      end
      rtwc_pkg::ST_CHECK: begin
        // hold the result until the output slot is free
        if (!m_valid_q || m_axis_tready) begin
          emit    = 1'b1;
          state_d = rtwc_pkg::ST_IDLE;
        end
      end
      default: state_d = rtwc_pkg::ST_IDLE;
    endcase
  end

  // ---- leg endpoints and squares ----
  always_comb begin
    ax = pos_x_q;
    ay = pos_y_q;
    bx = leg_home_q ? depot_x_q[CW-1:0] : item_x_q;
    by = leg_home_q ? depot_y_q[CW-1:0] : item_y_q;
    d2 = (2*CW+1)'(sq_q) + (2*CW+1)'(dy_q * dy_q);
  end

  rtwc_sqrt #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (RadW'(d2)),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // ---- time and load arithmetic ----
  always_comb begin
    leg_sum   = SumW'(elapsed_q) + SumW'(root);
    leg_sat   = (leg_sum > SumW'(rtwc_pkg::TimeMax)) ? rtwc_pkg::TimeMax : leg_sum[TimeW-1:0];
    close_ext = CmpW'({close_q, {FRAC_BITS{1'b0}}});
    late      = CmpW'(leg_sat) > close_ext;
    open_ext  = CmpW'({open_q, {FRAC_BITS{1'b0}}});
    serv_sum  = CmpW'(elapsed_q) + CmpW'({serv_q, {FRAC_BITS{1'b0}}});
    due_ext   = CmpW'({depot_due_q, {FRAC_BITS{1'b0}}});
    fin_ok    = ok_q && !(CmpW'(elapsed_q) > due_ext)
                && !(load_q > LoadW'(veh_cap_q));
    load_base = at_start_q ? '0 : load_q;
    load_sum  = (LoadW+1)'(load_base) + (LoadW+1)'(demand);

    elapsed_d = elapsed_q;
    unique case (state_q)
      rtwc_pkg::ST_IDLE: if (accept && at_start_q) elapsed_d = '0;
      rtwc_pkg::ST_ADD:  elapsed_d = leg_sat;
      rtwc_pkg::ST_OPEN: begin
        // wait for the window to open
        if (CmpW'(elapsed_q) < open_ext) begin
          elapsed_d = (open_ext > CmpW'(rtwc_pkg::TimeMax)) ? rtwc_pkg::TimeMax
                                                             : open_ext[TimeW-1:0];
        end
      end
      rtwc_pkg::ST_SERVE: begin
        elapsed_d = (serv_sum > CmpW'(rtwc_pkg::TimeMax)) ? rtwc_pkg::TimeMax
                                                           : serv_sum[TimeW-1:0];
      end
      default: elapsed_d = elapsed_q;
    endcase
  end

  // ---- control and route state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depot_x_q   <= '0;
      depot_y_q   <= '0;
      depot_due_q <= '1;
      veh_cap_q   <= '1;
      at_start_q  <= 1'b1;
      ok_q        <= 1'b1;
      leg_home_q  <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      elapsed_q   <= '0;
      load_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (rtwc_pkg::rtwc_reg_e'(cfg_idx_i))
          rtwc_pkg::REG_DEPOT_X:   depot_x_q   <= cfg_wdata_i[FieldW-1:0];
          rtwc_pkg::REG_DEPOT_Y:   depot_y_q   <= cfg_wdata_i[FieldW-1:0];
          rtwc_pkg::REG_DEPOT_DUE: depot_due_q <= cfg_wdata_i[TfW-1:0];
          rtwc_pkg::REG_VEH_CAP:   veh_cap_q   <= cfg_wdata_i[TfW-1:0];
          default: ;
        endcase
      end

      elapsed_q <= elapsed_d;

      if (accept) begin
        load_q     <= load_sum[LoadW] ? rtwc_pkg::LoadMax : load_sum[LoadW-1:0];
        leg_home_q <= 1'b0;
        if (at_start_q) begin
          // start the route at the depot
          pos_x_q    <= depot_x_q[CW-1:0];
          pos_y_q    <= depot_y_q[CW-1:0];
          ok_q       <= 1'b1;
          at_start_q <= 1'b0;
        end
      end

      if (state_q == rtwc_pkg::ST_ADD && !leg_home_q && late) ok_q <= 1'b0;

      if (state_q == rtwc_pkg::ST_SERVE) begin
        pos_x_q    <= item_x_q;
        pos_y_q    <= item_y_q;
        leg_home_q <= last_q;
      end

      if (emit) begin
        m_valid_q  <= 1'b1;
        at_start_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_x_q <= s_axis_tdata[CW-1:0];
      item_y_q <= s_axis_tdata[FieldW +: CW];
      open_q   <= s_axis_tdata[55:40];
      close_q  <= s_axis_tdata[71:56];
      serv_q   <= s_axis_tdata[87:72];
      last_q   <= s_axis_tlast;
    end
    if (state_q == rtwc_pkg::ST_DIFF) begin
      dx_q <= (ax > bx) ? (ax - bx) : (bx - ax);
      dy_q <= (ay > by) ? (ay - by) : (by - ay);
    end
    if (state_q == rtwc_pkg::ST_SQX) begin
      sq_q <= dx_q * dx_q;
    end
    if (emit) begin
      out_data_q <= {7'd0, load_q, elapsed_q, fin_ok};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---- assertions ----
  a_root_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == rtwc_pkg::ST_ROOT))
    else $error("square root finished outside its wait state");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && at_start_q) |=> (load_q == LoadW'($past(demand))))
    else $error("route start did not restart the load");

  a_emit_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == rtwc_pkg::ST_CHECK))
    else $error("result raised outside the final check");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (at_start_q && state_q == rtwc_pkg::ST_IDLE))
    else $error("route not closed after result");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stream testbench of the route time window checker
// Streams customer routes through the block while the depot registers change
// between phases. A scoreboard tracks route position, time and load, and
// checks each route result field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int FracBits     = rtwc_pkg::FracBitsDef;
  localparam int SettleCycles = 100;
  localparam int CycleLimit   = 1000000;

  typedef struct {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [15:0] demand;
    logic [15:0] win_open;
    logic [15:0] win_close;
    logic [15:0] service;
    logic        ends_route;
  } customer_t;

  typedef struct {
    logic        feasible;
    logic [31:0] route_time;
    logic [23:0] route_load;
  } route_result_t;

  class route_ledger;
    logic [11:0] depot_x = '0;
    logic [11:0] depot_y = '0;
    logic [15:0] depot_due = 16'hFFFF;
    logic [15:0] capacity = 16'hFFFF;
    logic [11:0] pos_x = '0;
    logic [11:0] pos_y = '0;
    logic [31:0] elapsed = '0;
    logic [23:0] load_sum = '0;
    bit          route_ok = 1'b1;
    bit          at_start = 1'b1;
    route_result_t expected_q[$];
    int unsigned mismatches = 0;
    int unsigned routes_checked = 0;

    function void set_reg(rtwc_pkg::rtwc_reg_e idx, logic [15:0] value);
      case (idx)
        rtwc_pkg::REG_DEPOT_X:   depot_x = value[11:0];
        rtwc_pkg::REG_DEPOT_Y:   depot_y = value[11:0];
        rtwc_pkg::REG_DEPOT_DUE: depot_due = value;
        rtwc_pkg::REG_VEH_CAP:   capacity = value;
        default: ;
      endcase
    endfunction

    // travel leg, floor(sqrt(dx^2 + dy^2)) in fixed point, found bit by bit
    function logic [31:0] leg_length(logic [11:0] ax, logic [11:0] ay,
                                     logic [11:0] bx, logic [11:0] by);
      longint unsigned dx, dy, radicand, root, cand;
      dx = (ax > bx) ? longint'(ax) - longint'(bx) : longint'(bx) - longint'(ax);
      dy = (ay > by) ? longint'(ay) - longint'(by) : longint'(by) - longint'(ay);
      radicand = (dx * dx + dy * dy) << (2 * FracBits);
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= radicand) root = cand;
      end
      return root[31:0];
    endfunction

    function logic [31:0] time_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
    endfunction

    function void note_customer(customer_t c);
      logic [24:0]   load_next;
      logic [31:0]   open_t, close_t, serve_t;
      route_result_t res;
      open_t  = 32'(c.win_open) << FracBits;
      close_t = 32'(c.win_close) << FracBits;
      serve_t = 32'(c.service) << FracBits;
      if (at_start) begin
        pos_x    = depot_x;
        pos_y    = depot_y;
        elapsed  = '0;
        load_sum = '0;
        route_ok = 1'b1;
        at_start = 1'b0;
      end
      load_next = {1'b0, load_sum} + 25'(c.demand);
      load_sum  = load_next[24] ? '1 : load_next[23:0];
      elapsed = time_add(elapsed, leg_length(pos_x, pos_y, c.cx, c.cy));
      // late arrival spoils the route but the sums carry on
      if (elapsed > close_t) route_ok = 1'b0;
      if (elapsed < open_t) elapsed = open_t;
      elapsed = time_add(elapsed, serve_t);
      pos_x = c.cx;
      pos_y = c.cy;
      if (!c.ends_route) return;
      elapsed = time_add(elapsed, leg_length(pos_x, pos_y, depot_x, depot_y));
      if (elapsed > (32'(depot_due) << FracBits)) route_ok = 1'b0;
      if (load_sum > 24'(capacity)) route_ok = 1'b0;
      res.feasible   = route_ok;
      res.route_time = elapsed;
      res.route_load = load_sum;
      expected_q.insert(expected_q.size(), res);
      at_start = 1'b1;
    endfunction

    function void check_result(route_result_t got);
      route_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: route result with none expected: feasible=%0b time=%h load=%h",
                 $time, got.feasible, got.route_time, got.route_load);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      routes_checked++;
      if (got.feasible !== want.feasible) begin
        $display("%0t: feasible mismatch: expected %0b, actual %0b",
                 $time, want.feasible, got.feasible);
        mismatches++;
      end
      if (got.route_time !== want.route_time) begin
        $display("%0t: route_time mismatch: expected %h, actual %h",
                 $time, want.route_time, got.route_time);
        mismatches++;
      end
      if (got.route_load !== want.route_load) begin
        $display("%0t: route_load mismatch: expected %h, actual %h",
                 $time, want.route_load, got.route_load);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic [rtwc_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tlast;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [rtwc_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_we_i;
  logic [rtwc_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [rtwc_pkg::CfgDataW-1:0] cfg_wdata_i;

  route_ledger ledger = new;
  bit          calm = 1'b0;
  int unsigned customers_sent = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;

  route_time_window_check i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d route results outstanding",
               $time, ledger.expected_q.size());
      $display("** route_time_window_check: FAILED **");
      $finish;
    end
  end

  // result side: check each accepted result, then pick the next ready level
  initial begin
    route_result_t got;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.feasible   = m_axis_tdata[0];
        got.route_time = m_axis_tdata[32:1];
        got.route_load = m_axis_tdata[56:33];
        ledger.check_result(got);
      end
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  task automatic send_customer(customer_t c);
    if (!calm && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.service, c.win_close, c.win_open, c.demand, c.cy, c.cx};
    s_axis_tlast  <= c.ends_route;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ledger.note_customer(c);
    customers_sent++;
  endtask

  // drop valid, wait for every route result, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (ledger.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(rtwc_pkg::rtwc_reg_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    ledger.set_reg(idx, value);
  endtask

  task automatic program_regs(logic [15:0] dx, logic [15:0] dy,
                              logic [15:0] due, logic [15:0] cap);
    put_reg(rtwc_pkg::REG_DEPOT_X, dx);
    put_reg(rtwc_pkg::REG_DEPOT_Y, dy);
    put_reg(rtwc_pkg::REG_DEPOT_DUE, due);
    put_reg(rtwc_pkg::REG_VEH_CAP, cap);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 16'hFFFF;
    if (r < 50) return 16'h0000;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic customer_t random_customer(bit ends);
    customer_t   c;
    int unsigned r;
    c.cx = 12'($urandom_range(0, 4095));
    c.cy = 12'($urandom_range(0, 4095));
    c.demand = ($urandom_range(99) < 60) ? 16'($urandom_range(0, 3000))
                                         : 16'($urandom_range(0, 65535));
    r = $urandom_range(99);
    if (r < 45) begin
      c.win_open  = 16'($urandom_range(0, 2000));
      c.win_close = 16'hFFFF;
    end else if (r < 80) begin
      c.win_open  = 16'($urandom_range(0, 30000));
      c.win_close = 16'(c.win_open + $urandom_range(0, 35000));
    end else begin
      c.win_open  = 16'($urandom_range(0, 65535));
      c.win_close = 16'($urandom_range(0, 65535));
    end
    c.service = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 200))
                                          : 16'($urandom_range(0, 65535));
    c.ends_route = ends;
    return c;
  endfunction

  task automatic run_routes(int target);
    int sent, len, r;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      len = (r < 60) ? $urandom_range(1, 5) :
            (r < 92) ? $urandom_range(6, 15) : $urandom_range(16, 40);
      for (int k = 0; k < len; k++) send_customer(random_customer(k == len - 1));
      sent += len;
    end
  endtask

  initial begin
    customer_t c;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= rtwc_pkg::REG_DEPOT_X;
    cfg_wdata_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: depot at the origin, wide due time and capacity
    send_customer(customer_t'{12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1});
    send_customer(customer_t'{12'hFFF, 12'hFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 1'b1});
    // late arrival, route carries on to its end
    send_customer(customer_t'{12'hFFF, 12'd0, 16'd7, 16'd0, 16'd0, 16'd0, 1'b0});
    send_customer(customer_t'{12'd0, 12'hFFF, 16'd1, 16'd0, 16'hFFFF, 16'd10, 1'b1});
    // wait to a late opening plus long service saturates the time
    send_customer(customer_t'{12'd1, 12'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1});
    send_customer(customer_t'{12'd100, 12'd200, 16'd50, 16'd300, 16'd400, 16'd20, 1'b0});
    send_customer(customer_t'{12'd2000, 12'd1500, 16'd60, 16'd0, 16'd5000, 16'd5, 1'b0});
    send_customer(customer_t'{12'd2000, 12'd1500, 16'd70, 16'd9000, 16'd9000, 16'd0, 1'b1});

    // equality holds on window close, due time and capacity
    wait_idle();
    program_regs(16'd0, 16'd0, 16'd10, 16'd100);
    send_customer(customer_t'{12'd3, 12'd4, 16'd100, 16'd0, 16'd5, 16'd0, 1'b1});
    send_customer(customer_t'{12'd3, 12'd4, 16'd101, 16'd0, 16'd5, 16'd0, 1'b1});
    send_customer(customer_t'{12'd3, 12'd4, 16'd100, 16'd0, 16'd5, 16'd1, 1'b1});
    send_customer(customer_t'{12'd3, 12'd4, 16'd100, 16'd0, 16'd4, 16'd0, 1'b1});

    wait_idle();
    program_regs(16'hFFFF, 16'h0FFF, 16'hFFFF, 16'd0);
    send_customer(customer_t'{12'd0, 12'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1});
    send_customer(customer_t'{12'd0, 12'd0, 16'd1, 16'd0, 16'hFFFF, 16'd0, 1'b1});
    send_customer(customer_t'{12'hFFF, 12'hFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0});
    send_customer(customer_t'{12'd2048, 12'd1000, 16'd0, 16'd0, 16'hFFFF, 16'd3, 1'b1});

    wait_idle();
    program_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_customer(customer_t'{12'd0, 12'hFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1});
    send_customer(customer_t'{12'd1, 12'hFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1});

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        default: program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              pick_limit(), pick_limit());
      endcase
      calm = (phase == 2);
      if (phase == 3) begin
        run_routes(80);
        // hold requests until the block has drained
        wait_idle();
        // one long route of full demands saturates the load
        for (int k = 0; k < 260; k++) begin
          c = random_customer(k == 259);
          c.demand    = 16'hFFFF;
          c.win_close = 16'hFFFF;
          send_customer(c);
        end
        run_routes(80);
      end else begin
        run_routes(170);
      end
    end
    calm = 1'b0;
    wait_idle();

    $display("Sent %0d customers, checked %0d routes over %0d register settings.",
             customers_sent, ledger.routes_checked, settings_used);
    $display("Covered windows, saturation of time and load, and depot extremes.");
    if (ledger.mismatches == 0 && ledger.expected_q.size() == 0) begin
      $display("** route_time_window_check: PASSED **");
    end else begin
      $display("** route_time_window_check: FAILED **");
    end
    $finish;
  end

endmodule
